>>> rtl/drxps_pkg.sv
// drx profile select package: tables, status codes, register indexes, stage types
// no dependencies; imported by drx_profile_select_top
package drxps_pkg;

   // result status codes
   typedef enum logic [2:0] {
      ST_CONFIGURED = 3'd0,
      ST_KEPT       = 3'd1,
      ST_RELEASED   = 3'd2,
      ST_FAILED     = 3'd3,
      ST_NO_CQI     = 3'd4
   } status_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_LC_GBR    = 3'd0,
      REG_LC_NONGBR = 3'd1,
      REG_INACT     = 3'd2,
      REG_RETX      = 3'd3,
      REG_CQI_PER   = 3'd4,
      REG_MIN_LC    = 3'd5,
      REG_OD_DIV    = 3'd6,
      REG_RI_BASE   = 3'd7
   } reg_idx_type;

   // number of pipeline stages
   localparam int NSTG = 6;

   // long cycle table, value = 2^exp, times five when the five flag is set
   localparam logic [11:0] LONG_VAL [16] = '{
      12'd10, 12'd20, 12'd32, 12'd40, 12'd64, 12'd80, 12'd128, 12'd160,
      12'd256, 12'd320, 12'd512, 12'd640, 12'd1024, 12'd1280, 12'd2048, 12'd2560};
   localparam logic [3:0] LONG_EXP [16] = '{
      4'd1, 4'd2, 4'd5, 4'd3, 4'd6, 4'd4, 4'd7, 4'd5,
      4'd8, 4'd6, 4'd9, 4'd7, 4'd10, 4'd8, 4'd11, 4'd9};
   localparam logic [15:0] LONG_FIVE = 16'b1010_1010_1010_1011;

   // on-duration table
   localparam logic [7:0] ONDUR_VAL [16] = '{
      8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd8, 8'd10,
      8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd80, 8'd100, 8'd200};

   // short cycle table, factored the same way as the long table
   localparam logic [9:0] SHORT_VAL [16] = '{
      10'd2, 10'd5, 10'd8, 10'd10, 10'd16, 10'd20, 10'd32, 10'd40,
      10'd64, 10'd80, 10'd128, 10'd160, 10'd256, 10'd320, 10'd512, 10'd640};
   localparam logic [3:0] SHORT_EXP [16] = '{
      4'd1, 4'd0, 4'd3, 4'd1, 4'd4, 4'd2, 4'd5, 4'd3,
      4'd6, 4'd4, 4'd7, 4'd5, 4'd8, 4'd6, 4'd9, 4'd7};
   localparam logic [15:0] SHORT_FIVE = 16'b1010_1010_1010_1010;

   // reciprocal of five, scaled by 2^18
   localparam logic [16:0] RECIP5 = 17'd52429;

   // divider partial state
   typedef struct packed {
      logic [8:0]  r;
      logic [11:0] n;
      logic [11:0] q;
   } div_type;

   // pipeline stage contents
   typedef struct packed {
      logic        done;
      status_type  status;
      status_type  fail_st;
      logic [11:0] cycle;
      logic [3:0]  lc_code;
      logic [3:0]  lc_exp;
      logic        lc_five;
      logic [7:0]  dvs;
      logic [11:0] ri_off;
      logic        ri_pres;
      logic [10:0] gap;
      logic        want_short;
      logic [11:0] y;
      logic [9:0]  mq;
      logic [11:0] rem_off;
      div_type     dv;
      logic [3:0]  od_code;
      logic [7:0]  odv;
      logic [11:0] offset;
      logic        s_pres;
      logic [3:0]  s_code;
      logic [10:0] s_rep;
   } itm_type;

endpackage

>>> rtl/drx_profile_select_top.sv
// drx profile select top level: six-stage pipeline from request to response
// depends on drxps_pkg
//
// Usage
//  - req_ channel: one request per transfer, fields packed in req_tdata
//  - rsp_ channel: one response per request, in request order
//  - csr_ port: write registers only with no request in flight; not enforced
// Timing
//  - six register stages lie between the request transfer and the response
//    transfer; the response is driven from the last stage register
//  - one request per cycle sustained while the response side keeps up; the
//    on-duration divide by the programmable divisor is a restoring divider
//    spread four bits per stage over three stages, setting the pipeline depth
// Reset
//  - synchronous reset empties the pipeline and loads the register defaults
// Backpressure
//  - each stage holds while the one after it is full and stalled, so bubbles
//    are squeezed out and a request is still taken while the response waits
module drx_profile_select_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // qci_priority[3:0], has_cqi_resource[4], has_drx_resource[5],
   // current_long_cycle_code[9:6], ri_offset[21:10], ri_index_present[22],
   // ri_config_index[32:23], want_short_cycle[33], zero fill [39:34]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], drx_enabled[3], long_cycle_code[7:4], on_duration_code[11:8],
   // start_offset[23:12], inactivity_code[28:24], retx_code[31:29],
   // short_present[32], short_cycle_code[36:33], short_cycle_repeat[47:37]
   output logic [47:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [11:0] csr_wdata
);
   import drxps_pkg::*;

   // configuration registers
   logic [3:0]  lc_gbr_ff, lc_nongbr_ff;
   logic [4:0]  inact_ff;
   logic [2:0]  retx_ff;
   logic [11:0] cqi_per_ff, min_lc_ff;
   logic [7:0]  od_div_ff;
   logic [9:0]  ri_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lc_gbr_ff    <= '0;
         lc_nongbr_ff <= '0;
         inact_ff     <= '0;
         retx_ff      <= '0;
         cqi_per_ff   <= 12'd40;
         min_lc_ff    <= 12'd10;
         od_div_ff    <= 8'd10;
         ri_base_ff   <= 10'd161;
      end else if (csr_we) begin
         unique case (reg_idx_type'(csr_addr))
            REG_LC_GBR:    lc_gbr_ff    <= csr_wdata[3:0];
            REG_LC_NONGBR: lc_nongbr_ff <= csr_wdata[3:0];
            REG_INACT:     inact_ff     <= csr_wdata[4:0];
            REG_RETX:      retx_ff      <= csr_wdata[2:0];
            REG_CQI_PER:   cqi_per_ff   <= csr_wdata;
            REG_MIN_LC:    min_lc_ff    <= csr_wdata;
            REG_OD_DIV:    od_div_ff    <= csr_wdata[7:0];
            REG_RI_BASE:   ri_base_ff   <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // four restoring divide steps
   function automatic div_type div4(div_type din, logic [7:0] d);
      div_type v;
      v = din;
      for (int j = 0; j < 4; j++) begin
         v.r = {v.r[7:0], v.n[11]};
         v.n = {v.n[10:0], 1'b0};
         if (v.r >= {1'b0, d}) begin
            v.r = v.r - {1'b0, d};
            v.q = {v.q[10:0], 1'b1};
         end else begin
            v.q = {v.q[10:0], 1'b0};
         end
      end
      return v;
   endfunction

   // pipeline registers
   itm_type    st_ff [NSTG];
   itm_type    st_in [NSTG];
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] rdy;

   // per-stage ready: a stage moves when empty or when its successor moves
   always_comb begin
      rdy[NSTG-1] = !vld_ff[NSTG-1] || rsp_tready;
      for (int k = NSTG-2; k >= 0; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end
   assign req_tready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) vld_ff[0] <= req_tvalid;
         for (int k = 1; k < NSTG; k++) begin
            if (rdy[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0] && req_tvalid) st_ff[0] <= st_in[0];
      for (int k = 1; k < NSTG; k++) begin
         if (rdy[k] && vld_ff[k-1]) st_ff[k] <= st_in[k];
      end
   end

   // request fields
   logic [3:0]  q_prio, q_cur;
   logic        q_cqi, q_drx, q_pres, q_short;
   logic [11:0] q_rioff;
   logic [9:0]  q_riidx;
   assign q_prio  = req_tdata[3:0];
   assign q_cqi   = req_tdata[4];
   assign q_drx   = req_tdata[5];
   assign q_cur   = req_tdata[9:6];
   assign q_rioff = req_tdata[21:10];
   assign q_pres  = req_tdata[22];
   assign q_riidx = req_tdata[32:23];
   assign q_short = req_tdata[33];

   // stage 0: cycle choice, cap, keep and minimum checks, table lookup, ri gap
   always_comb begin
      logic [3:0]  code;
      logic [11:0] cyc;
      logic        hit;
      itm_type     s;
      s = '0;
      code = (q_prio >= 4'd1 && q_prio <= 4'd5) ? lc_gbr_ff : lc_nongbr_ff;
      cyc = LONG_VAL[code];
      if (cyc > cqi_per_ff) cyc = cqi_per_ff;
      hit = 1'b0;
      for (int i = 0; i < 16; i++) begin
         if (!hit && LONG_VAL[i] == cyc) begin
            hit = 1'b1;
            s.lc_code = 4'(i);
         end
      end
      s.fail_st    = q_drx ? ST_RELEASED : ST_FAILED;
      s.cycle      = cyc;
      s.lc_exp     = LONG_EXP[s.lc_code];
      s.lc_five    = LONG_FIVE[s.lc_code];
      s.dvs        = (od_div_ff == '0) ? 8'd1 : od_div_ff;
      s.ri_off     = q_rioff;
      s.ri_pres    = q_pres;
      s.gap        = 11'({1'b0, q_riidx} - {1'b0, ri_base_ff} + 11'd1);
      s.want_short = q_short;
      s.y          = q_rioff >> s.lc_exp;
      s.dv.n       = cyc;
      priority if (!q_cqi) begin
         s.done = 1'b1;  s.status = ST_NO_CQI;
      end else if (q_drx && cyc == LONG_VAL[q_cur]) begin
         s.done = 1'b1;  s.status = ST_KEPT;
      end else if (cyc < min_lc_ff || !hit || (q_pres && q_riidx < ri_base_ff)) begin
         s.done = 1'b1;  s.status = s.fail_st;
      end else begin
         s.done = 1'b0;  s.status = ST_CONFIGURED;
      end
      st_in[0] = s;
   end

   // stage 1: divide bits 11..8, offset quotient by five
   always_comb begin
      logic [28:0] prod;
      itm_type     s;
      s = st_ff[0];
      s.dv = div4(st_ff[0].dv, st_ff[0].dvs);
      prod = 29'(st_ff[0].y) * 29'(RECIP5);
      s.mq = prod[27:18];
      st_in[1] = s;
   end

   // stage 2: divide bits 7..4, remainder of ri offset by the cycle
   always_comb begin
      logic [11:0] mask, r5;
      itm_type     s;
      s = st_ff[1];
      s.dv = div4(st_ff[1].dv, st_ff[1].dvs);
      mask = (12'd1 << st_ff[1].lc_exp) - 12'd1;
      r5 = st_ff[1].y - 12'({st_ff[1].mq, 2'b00} + {2'b00, st_ff[1].mq});
      s.rem_off = st_ff[1].lc_five ?
                  ((12'(r5[2:0]) << st_ff[1].lc_exp) | (st_ff[1].ri_off & mask)) :
                  (st_ff[1].ri_off & mask);
      st_in[2] = s;
   end

   // stage 3: divide bits 3..0
   always_comb begin
      itm_type s;
      s = st_ff[2];
      s.dv = div4(st_ff[2].dv, st_ff[2].dvs);
      st_in[3] = s;
   end

   // stage 4: on-duration rounding, fit check, start offset
   always_comb begin
      logic [11:0] ond;
      logic        hit;
      itm_type     s;
      s = st_ff[3];
      ond = (st_ff[3].ri_pres && 12'(st_ff[3].gap) >= st_ff[3].dv.q) ?
            12'(st_ff[3].gap) : st_ff[3].dv.q;
      hit = 1'b0;
      s.od_code = '0;
      for (int i = 0; i < 16; i++) begin
         if (!hit && 12'(ONDUR_VAL[i]) >= ond) begin
            hit = 1'b1;
            s.od_code = 4'(i);
         end
      end
      s.odv = ONDUR_VAL[s.od_code];
      if (!st_ff[3].done && (!hit || 12'(s.odv) >= st_ff[3].cycle)) begin
         s.done = 1'b1;
         s.status = st_ff[3].fail_st;
      end
      if (s.odv > 8'd2)
         s.offset = (st_ff[3].rem_off == '0) ? st_ff[3].cycle - 12'd1
                                             : st_ff[3].rem_off - 12'd1;
      else
         s.offset = st_ff[3].rem_off;
      st_in[4] = s;
   end

   // stage 5: first short cycle that divides the long cycle and fits
   always_comb begin
      logic [3:0]  sh;
      logic        f5;
      logic [10:0] base;
      itm_type     s;
      s = st_ff[4];
      s.s_pres = 1'b0;
      s.s_code = '0;
      sh = '0;
      f5 = 1'b0;
      for (int i = 0; i < 16; i++) begin
         if (!s.s_pres && st_ff[4].want_short
             && {2'b00, SHORT_VAL[i]} > {4'b0, st_ff[4].odv}
             && {2'b00, SHORT_VAL[i]} < st_ff[4].cycle
             && SHORT_EXP[i] <= st_ff[4].lc_exp
             && !(SHORT_FIVE[i] && !st_ff[4].lc_five)
             && {1'b0, SHORT_VAL[i]} >= {2'b00, st_ff[4].odv, 1'b0}) begin
            s.s_pres = 1'b1;
            s.s_code = 4'(i);
            sh = st_ff[4].lc_exp - SHORT_EXP[i];
            f5 = st_ff[4].lc_five && !SHORT_FIVE[i];
         end
      end
      base = 11'd1 << sh;
      s.s_rep = !s.s_pres ? 11'd0 : (f5 ? 11'({base, 2'b00} + {2'b00, base}) : base);
      st_in[5] = s;
   end

   // response packing
   itm_type o;
   assign o = st_ff[NSTG-1];
   assign rsp_tvalid = vld_ff[NSTG-1];
   assign rsp_tdata = o.done ? {45'd0, o.status} :
                      {o.s_rep, o.s_code, o.s_pres, retx_ff, inact_ff, o.offset,
                       o.od_code, o.lc_code, 1'b1, ST_CONFIGURED};

   // checks on the configured profile
   a_od_below_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == ST_CONFIGURED |->
         12'(ONDUR_VAL[rsp_tdata[11:8]]) < LONG_VAL[rsp_tdata[7:4]])
      else $error("on-duration not below long cycle");

   a_offset_in_cycle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == ST_CONFIGURED |->
         rsp_tdata[23:12] < LONG_VAL[rsp_tdata[7:4]])
      else $error("start offset outside long cycle");

   a_short_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == ST_CONFIGURED && rsp_tdata[32] |->
         {1'b0, SHORT_VAL[rsp_tdata[36:33]]} >= {2'b00, ONDUR_VAL[rsp_tdata[11:8]], 1'b0}
         && rsp_tdata[47:37] != 11'd0)
      else $error("short cycle leaves too little sleep");

endmodule

>>> tb/sv/testbench.sv
// testbench for drx_profile_select_top: directed table, then random requests per csr profile
// depends on drxps_pkg, drx_profile_select_top; results checked by typed rows or predictor
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import drxps_pkg::*;

   typedef struct {
      logic [3:0]  prio;
      logic        has_cqi;
      logic        has_drx;
      logic [3:0]  cur_code;
      logic [11:0] ri_off;
      logic        ri_pres;
      logic [9:0]  ri_idx;
      logic        want_short;
   } ue_req_type;

   typedef struct {
      status_type  status;
      logic        drx_en;
      logic [3:0]  lc_code;
      logic [3:0]  od_code;
      logic [11:0] start_off;
      logic [4:0]  inact;
      logic [2:0]  retx;
      logic        s_pres;
      logic [3:0]  s_code;
      logic [10:0] s_rep;
   } drx_profile_type;

   typedef struct {
      ue_req_type      rq;
      bit              typed;
      drx_profile_type exp;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [11:0] csr_wdata;

   // shadow of the csr registers
   int lc_gbr, lc_nongbr, inact_code, retx_code, cqi_per, min_cycle, od_div, ri_base;

   drx_profile_type profiles_due[$];
   int  mismatches;
   int  n_sent, n_checked;
   int  rsp_hold;
   bit  req_steady, rsp_steady;

   drx_profile_select_top dut (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("timeout with %0d profiles outstanding", profiles_due.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // expected profile for one request under the current registers
   function automatic drx_profile_type predict_profile(ue_req_type r);
      drx_profile_type o;
      status_type      fail_st;
      int cycle, ondur, dv, gap, lc, od, s;
      o = '{ST_CONFIGURED, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      fail_st = r.has_drx ? ST_RELEASED : ST_FAILED;
      cycle = (r.prio >= 1 && r.prio <= 5) ? int'(LONG_VAL[lc_gbr]) : int'(LONG_VAL[lc_nongbr]);
      if (!r.has_cqi) begin
         o.status = ST_NO_CQI;
         return o;
      end
      if (cycle > cqi_per) cycle = cqi_per;
      if (r.has_drx && cycle == int'(LONG_VAL[r.cur_code])) begin
         o.status = ST_KEPT;
         return o;
      end
      o.status = fail_st;
      if (cycle < min_cycle) return o;
      lc = -1;
      for (int i = 0; i < 16; i++) if (lc < 0 && int'(LONG_VAL[i]) == cycle) lc = i;
      if (lc < 0) return o;
      dv = (od_div == 0) ? 1 : od_div;
      ondur = cycle / dv;
      if (r.ri_pres) begin
         if (int'(r.ri_idx) < ri_base) return o;
         gap = int'(r.ri_idx) - ri_base + 1;
         if (gap >= ondur) ondur = gap;
      end
      od = -1;
      for (int i = 0; i < 16; i++) if (od < 0 && int'(ONDUR_VAL[i]) >= ondur) od = i;
      if (od < 0) return o;
      ondur = int'(ONDUR_VAL[od]);
      if (ondur >= cycle) return o;
      o.status    = ST_CONFIGURED;
      o.drx_en    = 1'b1;
      o.lc_code   = 4'(lc);
      o.od_code   = 4'(od);
      o.start_off = (ondur > 2) ? 12'((int'(r.ri_off) + cycle - 1) % cycle)
                                : 12'(int'(r.ri_off) % cycle);
      o.inact     = 5'(inact_code);
      o.retx      = 3'(retx_code);
      // first short cycle dividing the long one with enough sleep time
      if (r.want_short)
         for (int i = 0; i < 16; i++) begin
            s = int'(SHORT_VAL[i]);
            if (!o.s_pres && s > ondur && s < cycle && cycle % s == 0
                && s - ondur >= ondur) begin
               o.s_pres = 1'b1;
               o.s_code = 4'(i);
               o.s_rep  = 11'(cycle / s);
            end
         end
      return o;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      mismatches++;
      $display("mismatch on response %0d: %s got %0d expected %0d",
               n_checked, field, got, want);
   endtask

   // response side: random stalls, forced hold-offs, field compare
   initial begin
      drx_profile_type got, want;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got = '{status_type'(rsp_tdata[2:0]), rsp_tdata[3], rsp_tdata[7:4],
                    rsp_tdata[11:8], rsp_tdata[23:12], rsp_tdata[28:24],
                    rsp_tdata[31:29], rsp_tdata[32], rsp_tdata[36:33], rsp_tdata[47:37]};
            if (profiles_due.size() == 0) begin
               report_mismatch("unexpected response transfer", 1, 0);
            end else begin
               want = profiles_due.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status", got.status, want.status);
               if (got.drx_en !== want.drx_en)
                  report_mismatch("drx_enabled", got.drx_en, want.drx_en);
               if (got.lc_code !== want.lc_code)
                  report_mismatch("long_cycle_code", got.lc_code, want.lc_code);
               if (got.od_code !== want.od_code)
                  report_mismatch("on_duration_code", got.od_code, want.od_code);
               if (got.start_off !== want.start_off)
                  report_mismatch("start_offset", got.start_off, want.start_off);
               if (got.inact !== want.inact)
                  report_mismatch("inactivity_code", got.inact, want.inact);
               if (got.retx !== want.retx)
                  report_mismatch("retx_code", got.retx, want.retx);
               if (got.s_pres !== want.s_pres)
                  report_mismatch("short_present", got.s_pres, want.s_pres);
               if (got.s_code !== want.s_code)
                  report_mismatch("short_cycle_code", got.s_code, want.s_code);
               if (got.s_rep !== want.s_rep)
                  report_mismatch("short_cycle_repeat", got.s_rep, want.s_rep);
            end
            n_checked++;
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= rsp_steady || ($urandom_range(99) >= 35);
         end
      end
   end

   // one request transfer; expectation queued at the accepting edge
   task automatic send_req(ue_req_type r, bit typed, drx_profile_type exp);
      while (!req_steady && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, r.want_short, r.ri_idx, r.ri_pres, r.ri_off, r.cur_code,
                     r.has_drx, r.has_cqi, r.prio};
      do @(posedge clock); while (!req_tready);
      profiles_due.push_back(typed ? exp : predict_profile(r));
      n_sent++;
   endtask

   task automatic drain;
      req_tvalid <= 1'b0;
      while (profiles_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // one register write transfer; the caller drops the write enable
   task automatic write_reg(reg_idx_type idx, int val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= 12'(val);
      @(posedge clock);
      case (idx)
         REG_LC_GBR:    lc_gbr     = val;
         REG_LC_NONGBR: lc_nongbr  = val;
         REG_INACT:     inact_code = val;
         REG_RETX:      retx_code  = val;
         REG_CQI_PER:   cqi_per    = val;
         REG_MIN_LC:    min_cycle  = val;
         REG_OD_DIV:    od_div     = val;
         REG_RI_BASE:   ri_base    = val;
         default: ;
      endcase
   endtask

   task automatic load_profile(int v0, int v1, int v2, int v3, int v4, int v5, int v6, int v7);
      drain();
      write_reg(REG_LC_GBR, v0);
      write_reg(REG_LC_NONGBR, v1);
      write_reg(REG_INACT, v2);
      write_reg(REG_RETX, v3);
      write_reg(REG_CQI_PER, v4);
      write_reg(REG_MIN_LC, v5);
      write_reg(REG_OD_DIV, v6);
      write_reg(REG_RI_BASE, v7);
      csr_we <= 1'b0;
   endtask

   // random request, mostly with cqi and an ri index near the base
   function automatic ue_req_type random_req();
      ue_req_type r;
      int idx;
      r.prio       = 4'($urandom_range(15));
      r.has_cqi    = $urandom_range(9) != 0;
      r.has_drx    = 1'($urandom_range(1));
      r.cur_code   = 4'($urandom_range(15));
      r.ri_off     = 12'($urandom_range(4095));
      r.ri_pres    = $urandom_range(3) != 0;
      idx          = ri_base + int'($urandom_range(40)) - 2;
      r.ri_idx     = ($urandom_range(7) == 0 || idx < 0 || idx > 1023) ?
                     10'($urandom_range(1023)) : 10'(idx);
      r.want_short = $urandom_range(3) != 0;
      return r;
   endfunction

   initial begin
      dir_row_type     rows[$];
      drx_profile_type none;
      none = '{ST_CONFIGURED, 0, 0, 0, 0, 0, 0, 0, 0, 0};
      mismatches = 0; n_sent = 0; n_checked = 0; rsp_hold = 0;
      req_steady = 0; rsp_steady = 0;
      lc_gbr = 0; lc_nongbr = 0; inact_code = 0; retx_code = 0;
      cqi_per = 40; min_cycle = 10; od_div = 10; ri_base = 161;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= REG_LC_GBR;
      csr_wdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed rows at reset defaults: 10 subframe cycle, cap 40
      rows.push_back('{'{0, 0, 0, 0, 0, 0, 0, 0}, 1, '{ST_NO_CQI, 0, 0, 0, 0, 0, 0, 0, 0, 0}});
      rows.push_back('{'{0, 1, 0, 3, 4095, 0, 0, 1}, 1,
                       '{ST_CONFIGURED, 1, 0, 0, 5, 0, 0, 1, 0, 5}});
      rows.push_back('{'{15, 1, 1, 0, 100, 0, 0, 0}, 1, '{ST_KEPT, 0, 0, 0, 0, 0, 0, 0, 0, 0}});
      rows.push_back('{'{6, 1, 0, 5, 0, 1, 160, 0}, 1, '{ST_FAILED, 0, 0, 0, 0, 0, 0, 0, 0, 0}});
      rows.push_back('{'{1, 1, 1, 15, 7, 1, 0, 1}, 1, '{ST_RELEASED, 0, 0, 0, 0, 0, 0, 0, 0, 0}});
      rows.push_back('{'{2, 1, 0, 0, 0, 1, 1023, 1}, 1, '{ST_FAILED, 0, 0, 0, 0, 0, 0, 0, 0, 0}});
      rows.push_back('{'{5, 1, 0, 0, 9, 1, 161, 1}, 0, none});
      rows.push_back('{'{1, 1, 1, 1, 10, 1, 163, 1}, 0, none});
      rows.push_back('{'{3, 1, 0, 2, 2048, 1, 170, 0}, 0, none});
      rows.push_back('{'{4, 1, 1, 0, 1, 0, 1023, 1}, 0, none});
      rows.push_back('{'{7, 0, 1, 15, 4095, 1, 1023, 1}, 0, none});
      rows.push_back('{'{8, 1, 1, 9, 2730, 1, 162, 1}, 0, none});
      rows.push_back('{'{10, 1, 0, 15, 1365, 1, 512, 0}, 0, none});
      rows.push_back('{'{12, 1, 1, 6, 4094, 0, 341, 1}, 0, none});
      rows.push_back('{'{9, 1, 0, 10, 3, 1, 682, 1}, 0, none});
      foreach (rows[i]) send_req(rows[i].rq, rows[i].typed, rows[i].exp);

      // profiles: defaults, then minimum settings, maximum settings, mixes
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: load_profile(0, 0, 0, 0, 40, 10, 10, 161);
            1: load_profile(0, 0, 0, 0, 2, 1, 1, 0);
            2: load_profile(15, 15, 31, 7, 2560, 2560, 255, 1023);
            3: load_profile(5, 9, 17, 3, 320, 20, 8, 161);
            4: load_profile(11, 13, 10, 5, 2560, 10, 0, 300);
            5: load_profile(15, 3, 21, 6, 1280, 64, 20, 100);
            default: load_profile($urandom_range(15), $urandom_range(15), $urandom_range(31),
                                  $urandom_range(7), $urandom_range(2560, 2),
                                  $urandom_range(80, 1), $urandom_range(255, 1),
                                  $urandom_range(1023));
         endcase
         req_steady = (ph == 3);
         rsp_steady = (ph == 3);
         for (int n = 0; n < 165; n++) begin
            // receiver holds off while requests keep coming
            if (ph == 4 && n == 40) rsp_hold = 150;
            // sender waits for every outstanding response
            if (ph == 5 && n == 80) begin
               req_tvalid <= 1'b0;
               while (profiles_due.size() != 0) @(posedge clock);
            end
            send_req(random_req(), 0, none);
         end
      end

      drain();
      $display("%0d requests sent, %0d responses checked over 7 csr profiles", n_sent, n_checked);
      $display("covered no-cqi, kept, released, failed, short cycle and backpressure cases");
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
